>>> rtl/core/epast_pkg.sv
`timescale 1ns / 1ps
// Package for the encoder PLL angle and speed tracker.
// Widths, register indexes, reset values, FSM states and control structs.
// No dependencies.
package epast_pkg;

    localparam int COUNT_BITS   = 12;
    localparam int ANGLE_BITS   = 16;
    localparam int PHASE_BITS   = ANGLE_BITS + 16;
    localparam int SPEED_BITS   = 32;
    localparam int POS_BITS     = 40;
    localparam int PP_BITS      = 7;
    localparam int GAIN_BITS    = 16;
    localparam int LIMIT_BITS   = 31;
    localparam int MODE_BITS    = 2;
    localparam int CFG_IDX_BITS = 3;
    localparam int ANGLE_SHIFT  = ANGLE_BITS - COUNT_BITS;

    // operand widths of the shared multiplier
    localparam int MUL_A_BITS   = GAIN_BITS + 1;
    localparam int MUL_B_BITS   = PHASE_BITS;
    localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;

    // rounding divider for the predicted mechanical step, two bits per cycle
    localparam int DIV_BITS     = SPEED_BITS + 2 - 16;
    localparam int DIV_CYCLES   = DIV_BITS / 2;
    localparam int DIV_CNT_BITS = $clog2(DIV_CYCLES);

    localparam logic [MODE_BITS-1:0] MODE_TICK = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_LOAD = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_INIT = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_POLE_PAIRS    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COUNT_REVERSE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KP_GAIN       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KI_GAIN       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPEED_LIMIT   = 3'd4;

    localparam logic [PP_BITS-1:0]    RST_POLE_PAIRS  = 7'd7;
    localparam logic [GAIN_BITS-1:0]  RST_KP_GAIN     = 16'd8192;
    localparam logic [GAIN_BITS-1:0]  RST_KI_GAIN     = 16'd256;
    localparam logic [LIMIT_BITS-1:0] RST_SPEED_LIMIT = 31'd268435456;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_INIT,
        ST_LOAD,
        ST_SAMPLE,
        ST_DIV,
        ST_PREDICT,
        ST_TRACK,
        ST_KI,
        ST_SPD,
        ST_PHASE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        MUL_PP,
        MUL_KI,
        MUL_KP
    } mul_sel_t;

    typedef struct packed {
        logic     item_load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_step;
        logic     init_write;
        logic     load_write;
        logic     sample_write;
        logic     predict_write;
        logic     track;
        logic     spd_write;
        logic     phase_write;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic                 sample_valid;
    } dp_status_t;

    function automatic logic [ANGLE_BITS-1:0] count_to_angle(
        input logic [COUNT_BITS-1:0] count,
        input logic                  reverse
    );
        logic [COUNT_BITS-1:0] c;
        c = reverse ? (~count + COUNT_BITS'(1)) : count;
        return {c, {ANGLE_SHIFT{1'b0}}};
    endfunction

endpackage

>>> rtl/core/epast_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the tracker: steps the datapath through one request.
// Depends on epast_pkg.
module epast_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  epast_pkg::dp_status_t  status,
    output epast_pkg::dp_cmd_t     cmd
);
    import epast_pkg::*;

    state_t                  state_reg, state_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (s_valid) state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                priority if (status.mode == MODE_INIT) state_next = ST_INIT;
                else if (status.mode == MODE_LOAD) state_next = ST_LOAD;
                else if (status.mode == MODE_TICK) begin
                    state_next = status.sample_valid ? ST_SAMPLE : ST_DIV;
                end else state_next = ST_DONE;
            end
            ST_INIT:     state_next = ST_DONE;
            ST_LOAD:     state_next = ST_DONE;
            ST_SAMPLE:   state_next = ST_TRACK;
            ST_DIV:      if (cnt_reg == DIV_CNT_BITS'(DIV_CYCLES - 1)) state_next = ST_PREDICT;
            ST_PREDICT:  state_next = ST_TRACK;
            ST_TRACK:    state_next = ST_KI;
            ST_KI:       state_next = ST_SPD;
            ST_SPD:      state_next = ST_PHASE;
            ST_PHASE:    state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.mul_sel  = MUL_PP;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE:     cmd.item_load = s_valid;
            ST_DISPATCH: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PP;
                cnt_next    = '0;
            end
            ST_INIT:     cmd.init_write = 1'b1;
            ST_LOAD:     cmd.load_write = 1'b1;
            ST_SAMPLE:   cmd.sample_write = 1'b1;
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + DIV_CNT_BITS'(1);
            end
            ST_PREDICT:  cmd.predict_write = 1'b1;
            ST_TRACK:    cmd.track = 1'b1;
            ST_KI: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KI;
            end
            ST_SPD: begin
                cmd.spd_write = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_KP;
            end
            ST_PHASE:    cmd.phase_write = 1'b1;
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/core/epast_dp.sv
`timescale 1ns / 1ps
// Datapath of the tracker: config registers, PLL and position state, shared
// multiplier, rounding divider and result registers. Depends on epast_pkg.
module epast_dp (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  epast_pkg::dp_cmd_t                      cmd,
    output epast_pkg::dp_status_t                   status,
    input  logic                                    cfg_write,
    input  logic [epast_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [epast_pkg::LIMIT_BITS-1:0]        cfg_data,
    input  logic [epast_pkg::MODE_BITS-1:0]         s_mode,
    input  logic                                    s_sample_valid,
    input  logic [epast_pkg::COUNT_BITS-1:0]        s_raw_count,
    input  logic signed [epast_pkg::POS_BITS-1:0]   s_position_value,
    output logic [epast_pkg::ANGLE_BITS-1:0]        m_pll_angle_out,
    output logic signed [epast_pkg::SPEED_BITS-1:0] m_pll_speed_out,
    output logic [epast_pkg::ANGLE_BITS-1:0]        m_mech_angle_out,
    output logic signed [epast_pkg::POS_BITS-1:0]   m_position_out,
    output logic [epast_pkg::COUNT_BITS-1:0]        m_count_out
);
    import epast_pkg::*;

    // configuration
    logic [PP_BITS-1:0]    pole_pairs_reg;
    logic                  count_reverse_reg;
    logic [GAIN_BITS-1:0]  kp_gain_reg;
    logic [GAIN_BITS-1:0]  ki_gain_reg;
    logic [LIMIT_BITS-1:0] speed_limit_reg;

    // tracker state
    logic [PHASE_BITS-1:0]        pll_phase_reg;
    logic signed [SPEED_BITS-1:0] pll_speed_reg;
    logic [ANGLE_BITS-1:0]        shaft_angle_reg;
    logic [ANGLE_BITS-1:0]        prev_shaft_angle_reg;
    logic signed [POS_BITS-1:0]   turn_position_reg;
    logic [COUNT_BITS-1:0]        last_count_reg;

    // current request
    logic [MODE_BITS-1:0]       mode_reg;
    logic                       sample_valid_reg;
    logic [COUNT_BITS-1:0]      raw_count_reg;
    logic [ANGLE_BITS-1:0]      angle_in_reg;
    logic signed [POS_BITS-1:0] position_value_reg;

    // working registers
    logic [PHASE_BITS-1:0]        meas_reg;
    logic signed [PHASE_BITS-1:0] err_reg;
    logic signed [MUL_P_BITS-1:0] prod_reg;
    logic [DIV_BITS-1:0]          div_dq_reg, div_dq_next;
    logic [PP_BITS-1:0]           div_rem_reg, div_rem_next;
    logic                         div_neg_reg;

    logic [PP_BITS-1:0]           pp_eff;
    logic signed [MUL_A_BITS-1:0] mul_a;
    logic signed [MUL_B_BITS-1:0] mul_b;
    logic signed [MUL_P_BITS-1:0] mul_p;
    logic signed [DIV_BITS+15:0]  div_num;
    logic [DIV_BITS-1:0]          div_n1;
    logic [PP_BITS:0]             rem_s;
    logic [DIV_BITS-1:0]          quot;
    logic signed [ANGLE_BITS-1:0] delta;
    logic signed [POS_BITS:0]     pos_sum;
    logic signed [POS_BITS-1:0]   pos_sat;
    logic signed [SPEED_BITS:0]   spd_sum;
    logic signed [SPEED_BITS:0]   lim_ext;
    logic signed [SPEED_BITS-1:0] spd_clamped;
    logic signed [PHASE_BITS-1:0] kp_term;

    assign pp_eff = (pole_pairs_reg == '0) ? PP_BITS'(1) : pole_pairs_reg;

    assign status.mode         = mode_reg;
    assign status.sample_valid = sample_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pole_pairs_reg    <= RST_POLE_PAIRS;
            count_reverse_reg <= 1'b0;
            kp_gain_reg       <= RST_KP_GAIN;
            ki_gain_reg       <= RST_KI_GAIN;
            speed_limit_reg   <= RST_SPEED_LIMIT;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_POLE_PAIRS:    pole_pairs_reg    <= cfg_data[PP_BITS-1:0];
                CFG_COUNT_REVERSE: count_reverse_reg <= cfg_data[0];
                CFG_KP_GAIN:       kp_gain_reg       <= cfg_data[GAIN_BITS-1:0];
                CFG_KI_GAIN:       ki_gain_reg       <= cfg_data[GAIN_BITS-1:0];
                CFG_SPEED_LIMIT:   speed_limit_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // multiplier operands
    always_comb begin
        unique case (cmd.mul_sel)
            MUL_PP: begin
                mul_a = MUL_A_BITS'(pp_eff);
                mul_b = MUL_B_BITS'(angle_in_reg);
            end
            MUL_KI: begin
                mul_a = MUL_A_BITS'(ki_gain_reg);
                mul_b = err_reg;
            end
            MUL_KP: begin
                mul_a = MUL_A_BITS'(kp_gain_reg);
                mul_b = err_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // speed / (pole_pairs * 2^16), rounded: floor(floor(num / 2^16) / pp)
    assign div_num = (DIV_BITS+16)'(pll_speed_reg)
                   + (DIV_BITS+16)'({pp_eff, 15'b0});
    assign div_n1  = div_num[DIV_BITS+15:16];

    always_comb begin
        div_dq_next  = div_dq_reg;
        div_rem_next = div_rem_reg;
        rem_s        = '0;
        for (int i = 0; i < 2; i++) begin
            rem_s = {div_rem_next, div_dq_next[DIV_BITS-1]};
            if (rem_s >= {1'b0, pp_eff}) begin
                div_rem_next = PP_BITS'(rem_s - {1'b0, pp_eff});
                div_dq_next  = {div_dq_next[DIV_BITS-2:0], 1'b1};
            end else begin
                div_rem_next = rem_s[PP_BITS-1:0];
                div_dq_next  = {div_dq_next[DIV_BITS-2:0], 1'b0};
            end
        end
    end
    assign quot = div_neg_reg ? ~div_dq_reg : div_dq_reg;

    // position tracking with saturation
    assign delta   = signed'(shaft_angle_reg - prev_shaft_angle_reg);
    assign pos_sum = (POS_BITS+1)'(turn_position_reg) + (POS_BITS+1)'(delta);
    assign pos_sat = (pos_sum[POS_BITS] != pos_sum[POS_BITS-1])
                   ? (pos_sum[POS_BITS] ? {1'b1, {(POS_BITS-1){1'b0}}}
                                        : {1'b0, {(POS_BITS-1){1'b1}}})
                   : pos_sum[POS_BITS-1:0];

    // speed integration with clamp
    assign lim_ext = (SPEED_BITS+1)'(speed_limit_reg);
    assign spd_sum = (SPEED_BITS+1)'(pll_speed_reg)
                   + (SPEED_BITS+1)'(signed'(prod_reg[SPEED_BITS+15:16]));
    always_comb begin
        priority if (spd_sum > lim_ext) spd_clamped = SPEED_BITS'(lim_ext);
        else if (spd_sum < -lim_ext)    spd_clamped = SPEED_BITS'(-lim_ext);
        else                            spd_clamped = spd_sum[SPEED_BITS-1:0];
    end
    assign kp_term = prod_reg[PHASE_BITS+15:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pll_phase_reg        <= '0;
            pll_speed_reg        <= '0;
            shaft_angle_reg      <= '0;
            prev_shaft_angle_reg <= '0;
            turn_position_reg    <= '0;
            last_count_reg       <= '0;
        end else begin
            if (cmd.init_write) begin
                last_count_reg       <= raw_count_reg;
                shaft_angle_reg      <= angle_in_reg;
                prev_shaft_angle_reg <= angle_in_reg;
                turn_position_reg    <= POS_BITS'(angle_in_reg);
                pll_phase_reg        <= {prod_reg[ANGLE_BITS-1:0], 16'b0};
            end
            if (cmd.load_write) begin
                turn_position_reg    <= position_value_reg;
                prev_shaft_angle_reg <= shaft_angle_reg;
            end
            if (cmd.sample_write) begin
                last_count_reg  <= raw_count_reg;
                shaft_angle_reg <= angle_in_reg;
            end
            if (cmd.predict_write) begin
                shaft_angle_reg <= shaft_angle_reg + quot[ANGLE_BITS-1:0];
            end
            if (cmd.track) begin
                turn_position_reg    <= pos_sat;
                prev_shaft_angle_reg <= shaft_angle_reg;
            end
            if (cmd.spd_write) begin
                pll_speed_reg <= spd_clamped;
            end
            if (cmd.phase_write) begin
                pll_phase_reg <= pll_phase_reg + PHASE_BITS'(pll_speed_reg)
                               + PHASE_BITS'(kp_term);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.item_load) begin
            mode_reg           <= s_mode;
            sample_valid_reg   <= s_sample_valid;
            raw_count_reg      <= s_raw_count;
            angle_in_reg       <= count_to_angle(s_raw_count, count_reverse_reg);
            position_value_reg <= s_position_value;
            div_neg_reg        <= div_n1[DIV_BITS-1];
            div_dq_reg         <= div_n1[DIV_BITS-1] ? ~div_n1 : div_n1;
            div_rem_reg        <= '0;
        end else if (cmd.div_step) begin
            div_dq_reg  <= div_dq_next;
            div_rem_reg <= div_rem_next;
        end
        if (cmd.sample_write) begin
            meas_reg <= {prod_reg[ANGLE_BITS-1:0], 16'b0};
        end
        if (cmd.predict_write) begin
            meas_reg <= pll_phase_reg + PHASE_BITS'(pll_speed_reg);
        end
        if (cmd.track) begin
            err_reg <= signed'(meas_reg - pll_phase_reg);
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_p;
        end
        if (cmd.out_load) begin
            m_pll_angle_out  <= pll_phase_reg[PHASE_BITS-1:16];
            m_pll_speed_out  <= pll_speed_reg;
            m_mech_angle_out <= shaft_angle_reg;
            m_position_out   <= turn_position_reg;
            m_count_out      <= last_count_reg;
        end
    end

endmodule

>>> rtl/core/encoder_pll_angle_speed_tracker.sv
`timescale 1ns / 1ps
// Encoder PLL angle and speed tracker. A tick request takes an optional
// 12-bit encoder count and updates the electrical angle, PLL speed, mechanical
// angle, saturating multi-turn position and last count; every request returns
// all of them. The work is serial: one shared multiplier is used for pole
// pairs, ki and kp in turn. A tick without a fresh count adds the rounding
// division of speed by pole pairs, done two quotient bits per cycle. One
// request is in work at a time; a finished result waits in an output register,
// so the next request is taken while it is held.
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be issued while the block is idle. Depends on epast_pkg, epast_ctrl,
// epast_dp.
module encoder_pll_angle_speed_tracker (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [epast_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [epast_pkg::LIMIT_BITS-1:0]        cfg_data,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic [epast_pkg::MODE_BITS-1:0]         s_mode,
    input  logic                                    s_sample_valid,
    input  logic [epast_pkg::COUNT_BITS-1:0]        s_raw_count,
    input  logic signed [epast_pkg::POS_BITS-1:0]   s_position_value,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [epast_pkg::ANGLE_BITS-1:0]        m_pll_angle_out,
    output logic signed [epast_pkg::SPEED_BITS-1:0] m_pll_speed_out,
    output logic [epast_pkg::ANGLE_BITS-1:0]        m_mech_angle_out,
    output logic signed [epast_pkg::POS_BITS-1:0]   m_position_out,
    output logic [epast_pkg::COUNT_BITS-1:0]        m_count_out
);
    import epast_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    epast_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    epast_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_mode           (s_mode),
        .s_sample_valid   (s_sample_valid),
        .s_raw_count      (s_raw_count),
        .s_position_value (s_position_value),
        .m_pll_angle_out  (m_pll_angle_out),
        .m_pll_speed_out  (m_pll_speed_out),
        .m_mech_angle_out (m_mech_angle_out),
        .m_position_out   (m_position_out),
        .m_count_out      (m_count_out)
    );

endmodule

>>> verif/epast_checker.sv
`timescale 1ns / 1ps
// Scoreboard for encoder_pll_angle_speed_tracker: mirrors register writes,
// predicts each result from accepted requests and compares it field by field.
// Depends on epast_pkg.
module epast_checker (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [epast_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [epast_pkg::LIMIT_BITS-1:0]        cfg_data,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic [epast_pkg::MODE_BITS-1:0]         s_mode,
    input  logic                                    s_sample_valid,
    input  logic [epast_pkg::COUNT_BITS-1:0]        s_raw_count,
    input  logic [epast_pkg::POS_BITS-1:0]          s_position_value,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic [epast_pkg::ANGLE_BITS-1:0]        m_pll_angle_out,
    input  logic [epast_pkg::SPEED_BITS-1:0]        m_pll_speed_out,
    input  logic [epast_pkg::ANGLE_BITS-1:0]        m_mech_angle_out,
    input  logic [epast_pkg::POS_BITS-1:0]          m_position_out,
    input  logic [epast_pkg::COUNT_BITS-1:0]        m_count_out,
    output int                                      fail_count,
    output int                                      pending
);
    import epast_pkg::*;

    localparam longint COUNTS_PER_TURN = 4096;
    localparam longint POS_MAX = 64'sd549755813887;
    localparam longint POS_MIN = -POS_MAX - 1;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] pll_angle;
        logic [SPEED_BITS-1:0] pll_speed;
        logic [ANGLE_BITS-1:0] shaft_angle;
        logic [POS_BITS-1:0]   position;
        logic [COUNT_BITS-1:0] count;
    } tracker_out_t;

    // tracker state
    logic [PHASE_BITS-1:0] phase_acc;
    logic [SPEED_BITS-1:0] speed_acc;
    logic [ANGLE_BITS-1:0] mech_ang;
    logic [ANGLE_BITS-1:0] prev_mech;
    logic [POS_BITS-1:0]   turn_pos;
    logic [COUNT_BITS-1:0] last_cnt;

    // registers
    logic [PP_BITS-1:0]    pole_pairs;
    logic                  reverse;
    logic [GAIN_BITS-1:0]  kp;
    logic [GAIN_BITS-1:0]  ki;
    logic [LIMIT_BITS-1:0] speed_lim;

    tracker_out_t expected_q[$];
    int errors = 0;

    function automatic logic [ANGLE_BITS-1:0] scale_count(input logic [COUNT_BITS-1:0] raw);
        logic [COUNT_BITS-1:0] c;
        c = reverse ? COUNT_BITS'(COUNTS_PER_TURN - longint'(raw)) : raw;
        return ANGLE_BITS'((longint'(c) << ANGLE_BITS) / COUNTS_PER_TURN);
    endfunction

    function automatic logic [PHASE_BITS-1:0] elec_phase(input logic [ANGLE_BITS-1:0] mech,
                                                         input longint pp_eff);
        logic [ANGLE_BITS-1:0] e;
        e = ANGLE_BITS'(longint'(mech) * pp_eff);
        return {e, 16'h0000};
    endfunction

    function automatic tracker_out_t step_tracker(input logic [MODE_BITS-1:0]  mode,
                                                  input logic                  sv,
                                                  input logic [COUNT_BITS-1:0] raw,
                                                  input logic [POS_BITS-1:0]   pos_val);
        longint pp_eff, den, num, q, err, inc, spd, lim, p;
        logic [PHASE_BITS-1:0] meas, diff;
        logic [ANGLE_BITS-1:0] d16;
        tracker_out_t r;
        pp_eff = (pole_pairs == '0) ? 1 : longint'(pole_pairs);
        case (mode)
            MODE_INIT: begin
                last_cnt = raw;
                mech_ang = scale_count(raw);
                prev_mech = mech_ang;
                turn_pos = POS_BITS'(mech_ang);
                phase_acc = elec_phase(mech_ang, pp_eff);
            end
            MODE_LOAD: begin
                turn_pos = pos_val;
                prev_mech = mech_ang;
            end
            MODE_TICK: begin
                if (sv) begin
                    last_cnt = raw;
                    mech_ang = scale_count(raw);
                    meas = elec_phase(mech_ang, pp_eff);
                end else begin
                    // mechanical step = speed / (pp * 2^16), rounded half up
                    den = pp_eff << 16;
                    num = longint'($signed(speed_acc)) + den / 2;
                    q = num / den;
                    if ((num % den) != 0 && num < 0)
                        q = q - 1;
                    meas = phase_acc + speed_acc;
                    mech_ang = mech_ang + ANGLE_BITS'(q);
                end
                d16 = mech_ang - prev_mech;
                p = longint'($signed(turn_pos)) + longint'($signed(d16));
                if (p > POS_MAX) p = POS_MAX;
                if (p < POS_MIN) p = POS_MIN;
                turn_pos = POS_BITS'(p);
                prev_mech = mech_ang;

                diff = meas - phase_acc;
                err = longint'($signed(diff));
                inc = (longint'(ki) * err) >>> 16;
                spd = longint'($signed(speed_acc)) + inc;
                lim = longint'(speed_lim);
                if (spd > lim) spd = lim;
                if (spd < -lim) spd = -lim;
                speed_acc = SPEED_BITS'(spd);
                phase_acc = phase_acc + PHASE_BITS'(spd)
                          + PHASE_BITS'((longint'(kp) * err) >>> 16);
            end
            default: ;
        endcase
        r.pll_angle   = phase_acc[PHASE_BITS-1:16];
        r.pll_speed   = speed_acc;
        r.shaft_angle = mech_ang;
        r.position    = turn_pos;
        r.count       = last_cnt;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        tracker_out_t got;
        tracker_out_t want;
        if (!aresetn) begin
            phase_acc = '0;
            speed_acc = '0;
            mech_ang = '0;
            prev_mech = '0;
            turn_pos = '0;
            last_cnt = '0;
            pole_pairs = RST_POLE_PAIRS;
            reverse = 1'b0;
            kp = RST_KP_GAIN;
            ki = RST_KI_GAIN;
            speed_lim = RST_SPEED_LIMIT;
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_POLE_PAIRS:    pole_pairs = cfg_data[PP_BITS-1:0];
                    CFG_COUNT_REVERSE: reverse = cfg_data[0];
                    CFG_KP_GAIN:       kp = cfg_data[GAIN_BITS-1:0];
                    CFG_KI_GAIN:       ki = cfg_data[GAIN_BITS-1:0];
                    CFG_SPEED_LIMIT:   speed_lim = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = {m_pll_angle_out, m_pll_speed_out, m_mech_angle_out,
                       m_position_out, m_count_out};
                if (expected_q.size() == 0) begin
                    $display("%0t: result with no request outstanding: expected none, actual %h",
                             $time, got);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("pll_angle_out", want.pll_angle, got.pll_angle);
                    check_field("pll_speed_out", want.pll_speed, got.pll_speed);
                    check_field("mech_angle_out", want.shaft_angle, got.shaft_angle);
                    check_field("position_out", want.position, got.position);
                    check_field("count_out", want.count, got.count);
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(step_tracker(s_mode, s_sample_valid, s_raw_count,
                                                  s_position_value));
        end
        pending <= expected_q.size();
        fail_count <= errors;
    end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Top of the encoder_pll_angle_speed_tracker testbench: clock, reset, request
// and register stimulus, result back-pressure and the verdict.
// Depends on epast_pkg, encoder_pll_angle_speed_tracker and epast_checker.
module tb;
    import epast_pkg::*;

    localparam logic [MODE_BITS-1:0]    MODE_HOLD  = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE  = 3'd5;
    localparam logic [POS_BITS-1:0]     POS_TOP    = 40'h7FFFFFFFFF;
    localparam logic [POS_BITS-1:0]     POS_BOTTOM = 40'h8000000000;
    localparam int                      RX_HOLD_AT = 150;
    localparam int                      RX_HOLD_CYCLES = 400;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [LIMIT_BITS-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [MODE_BITS-1:0] s_mode = MODE_TICK;
    logic s_sample_valid = 1'b0;
    logic [COUNT_BITS-1:0] s_raw_count = '0;
    logic [POS_BITS-1:0] s_position_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [ANGLE_BITS-1:0] m_pll_angle_out;
    logic [SPEED_BITS-1:0] m_pll_speed_out;
    logic [ANGLE_BITS-1:0] m_mech_angle_out;
    logic [POS_BITS-1:0] m_position_out;
    logic [COUNT_BITS-1:0] m_count_out;

    int fail_count;
    int pending;

    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;
    int mode_cnt[4] = '{0, 0, 0, 0};
    int settings = 1;
    int track_cnt = 0;
    int track_vel = 12;

    always #5 aclk = ~aclk;

    encoder_pll_angle_speed_tracker uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_mode(s_mode), .s_sample_valid(s_sample_valid),
        .s_raw_count(s_raw_count), .s_position_value(s_position_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pll_angle_out(m_pll_angle_out), .m_pll_speed_out(m_pll_speed_out),
        .m_mech_angle_out(m_mech_angle_out), .m_position_out(m_position_out),
        .m_count_out(m_count_out)
    );

    epast_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_mode(s_mode), .s_sample_valid(s_sample_valid),
        .s_raw_count(s_raw_count), .s_position_value(s_position_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_pll_angle_out(m_pll_angle_out), .m_pll_speed_out(m_pll_speed_out),
        .m_mech_angle_out(m_mech_angle_out), .m_position_out(m_position_out),
        .m_count_out(m_count_out),
        .fail_count(fail_count), .pending(pending)
    );

    function automatic logic [POS_BITS-1:0] rand_position();
        return POS_BITS'({$urandom, $urandom});
    endfunction

    task automatic send_request(input logic [MODE_BITS-1:0]  mode,
                                input logic                  sv,
                                input logic [COUNT_BITS-1:0] raw,
                                input logic [POS_BITS-1:0]   pos);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_mode <= mode;
        s_sample_valid <= sv;
        s_raw_count <= raw;
        s_position_value <= pos;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        mode_cnt[mode]++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic set_config(input logic [PP_BITS-1:0]    pp,
                              input logic                  rev,
                              input logic [GAIN_BITS-1:0]  kp,
                              input logic [GAIN_BITS-1:0]  ki,
                              input logic [LIMIT_BITS-1:0] lim,
                              input bit                    spare);
        logic [CFG_IDX_BITS-1:0] idx_list[$];
        logic [LIMIT_BITS-1:0] data;
        drain();
        repeat (20) @(posedge aclk);
        idx_list = '{CFG_POLE_PAIRS, CFG_COUNT_REVERSE, CFG_KP_GAIN, CFG_KI_GAIN,
                     CFG_SPEED_LIMIT};
        if (spare)
            idx_list.push_back(CFG_SPARE);
        foreach (idx_list[i]) begin
            case (idx_list[i])
                CFG_POLE_PAIRS:    data = LIMIT_BITS'(pp);
                CFG_COUNT_REVERSE: data = LIMIT_BITS'(rev);
                CFG_KP_GAIN:       data = LIMIT_BITS'(kp);
                CFG_KI_GAIN:       data = LIMIT_BITS'(ki);
                CFG_SPEED_LIMIT:   data = lim;
                default:           data = LIMIT_BITS'($urandom);
            endcase
            cfg_index <= idx_list[i];
            cfg_data <= data;
            cfg_valid <= 1'b1;
            do @(posedge aclk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // mostly a smoothly moving encoder with dropped samples, plus jumps,
    // re-inits, position loads near the rails and idle-mode requests
    task automatic run_random(input int n);
        int roll;
        logic [POS_BITS-1:0] pos;
        repeat (n) begin
            if ($urandom_range(0, 63) == 0)
                tx_burst = !tx_burst;
            if ($urandom_range(0, 99) == 0)
                track_vel = $urandom_range(0, 400) - 200;
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                track_cnt = $urandom_range(0, 4095);
                send_request(MODE_INIT, 1'($urandom_range(0, 1)), COUNT_BITS'(track_cnt),
                             rand_position());
            end else if (roll < 6) begin
                case ($urandom_range(0, 2))
                    0: pos = rand_position();
                    1: pos = POS_TOP - POS_BITS'($urandom_range(0, 40000));
                    default: pos = POS_BOTTOM + POS_BITS'($urandom_range(0, 40000));
                endcase
                send_request(MODE_LOAD, 1'($urandom_range(0, 1)),
                             COUNT_BITS'($urandom_range(0, 4095)), pos);
            end else if (roll < 8) begin
                send_request(MODE_HOLD, 1'($urandom_range(0, 1)),
                             COUNT_BITS'($urandom_range(0, 4095)), rand_position());
            end else if (roll < 12) begin
                track_cnt = $urandom_range(0, 4095);
                send_request(MODE_TICK, 1'b1, COUNT_BITS'(track_cnt), rand_position());
            end else begin
                track_cnt = track_cnt + track_vel + $urandom_range(0, 8) - 4;
                send_request(MODE_TICK, $urandom_range(0, 3) != 0, COUNT_BITS'(track_cnt),
                             rand_position());
            end
        end
    endtask

    // result side: random stalls, burst stretches, one long hold-off
    initial begin
        int gap;
        int taken;
        taken = 0;
        forever begin
            if ($urandom_range(0, 63) == 0)
                rx_burst = !rx_burst;
            gap = rx_burst ? 0 : $urandom_range(0, 11);
            if (taken == RX_HOLD_AT)
                gap = RX_HOLD_CYCLES;
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: wrap, half turn, prediction, rail saturation
        send_request(MODE_INIT, 1'b0, 12'd0, 40'd0);
        send_request(MODE_TICK, 1'b1, 12'd4095, 40'd0);
        send_request(MODE_TICK, 1'b1, 12'd0, 40'd0);
        send_request(MODE_TICK, 1'b1, 12'd2048, 40'd0);
        send_request(MODE_TICK, 1'b1, 12'd4095, 40'd0);
        repeat (3) send_request(MODE_TICK, 1'b0, 12'd0, 40'd0);
        send_request(MODE_LOAD, 1'b1, 12'hABC, POS_TOP);
        send_request(MODE_TICK, 1'b1, 12'd512, 40'd0);
        send_request(MODE_LOAD, 1'b0, 12'd0, POS_BOTTOM);
        send_request(MODE_TICK, 1'b1, 12'd0, 40'd0);
        send_request(MODE_HOLD, 1'b1, 12'hFFF, 40'hFFFFFFFFFF);
        send_request(MODE_INIT, 1'b1, 12'hFFF, 40'h5555555555);
        repeat (2) send_request(MODE_TICK, 1'b0, 12'h555, 40'h0);
        send_request(MODE_LOAD, 1'b0, 12'hAAA, 40'hAAAAAAAAAA);
        run_random(160);

        set_config(7'd0, 1'b1, 16'hFFFF, 16'hFFFF, 31'h7FFFFFFF, 1'b0);
        run_random(180);
        set_config(7'd127, 1'b0, 16'd0, 16'd0, 31'd0, 1'b0);
        run_random(180);
        set_config(7'd64, 1'b1, 16'd8192, 16'd256, 31'd268435456, 1'b0);
        run_random(180);
        set_config(7'd1, 1'b0, 16'd40000, 16'd4000, 31'h7FFFFFFF, 1'b0);
        run_random(180);
        repeat (2) begin
            set_config(PP_BITS'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                       GAIN_BITS'($urandom_range(0, 65535)),
                       GAIN_BITS'($urandom_range(0, 65535)), LIMIT_BITS'($urandom), 1'b0);
            run_random(180);
        end
        set_config(RST_POLE_PAIRS, 1'b0, RST_KP_GAIN, RST_KI_GAIN, RST_SPEED_LIMIT, 1'b1);
        run_random(180);

        drain();
        repeat (40) @(posedge aclk);
        $display("Summary: %0d tick, %0d load, %0d init and %0d idle-mode requests over %0d settings,",
                 mode_cnt[MODE_TICK], mode_cnt[MODE_LOAD], mode_cnt[MODE_INIT],
                 mode_cnt[MODE_HOLD], settings);
        $display("  incl. pole pairs 0/1/64/127, both count directions, zero and full gains/limits");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #(5_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/epast_pkg.sv
rtl/core/epast_ctrl.sv
rtl/core/epast_dp.sv
rtl/core/encoder_pll_angle_speed_tracker.sv
verif/epast_checker.sv
verif/tb.sv
